>>> rtl/core/particle_collision_response_unit_assert.svh
// Assertion macros for the particle collision response unit.
// Used by the port checker; expects clk and rst_n in the scope of use.
`ifndef PARTICLE_COLLISION_RESPONSE_UNIT_ASSERT_SVH
`define PARTICLE_COLLISION_RESPONSE_UNIT_ASSERT_SVH

// Same-cycle implication, off during reset
`define PCR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset
`define PCR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Plain invariant, off during reset
`define PCR_ASSERT_HOLD(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

>>> rtl/core/pcr_pkg.sv
// Shared types, constants and helpers for the particle collision response unit.
// No dependencies; imported by every module of the block but the checker, which names its types directly.
`default_nettype none

package pcr_pkg;

    // Fixed-point field widths
    localparam int unsigned QW    = 20;  // Q10.10 position / velocity
    localparam int unsigned NW    = 16;  // Q1.14 normal component
    localparam int unsigned FW    = 16;  // Q0.16 restitution / timestep
    localparam int unsigned WW    = 27;  // reflected velocity before scaling

    // Configuration register reset values
    localparam logic [15:0] RESTITUTION_RST  = 16'd64880;
    localparam logic [15:0] TIMESTEP_RST     = 16'd1092;
    localparam logic [47:0] PLANE_NORMAL_RST = 48'd16384;
    localparam logic [59:0] BOX_RST          = 60'd0;

    // Saturation bounds, held at the width of the widest pre-saturation value
    localparam logic signed [27:0] SAT_HI = 28'sd524287;
    localparam logic signed [27:0] SAT_LO = -28'sd524288;

    // Axis of each box face: +x, +y, +z, -x, -y, -z
    localparam logic [1:0] FACE_AXIS [6] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_RESTITUTION  = 3'd0,
        REG_TIMESTEP     = 3'd1,
        REG_PLANE_NORMAL = 3'd2,
        REG_BOX_MIN      = 3'd3,
        REG_BOX_MAX      = 3'd4
    } cfg_reg_t;

    // Collider kinds
    localparam logic MODE_PLANE = 1'b0;
    localparam logic MODE_BOX   = 1'b1;

    typedef struct packed {
        logic [15:0] restitution;
        logic [15:0] timestep;
        logic [47:0] plane_normal;
        logic [59:0] box_min;
        logic [59:0] box_max;
    } cfg_t;

    typedef struct packed {
        logic               mode;
        logic signed [19:0] current_x;
        logic signed [19:0] current_y;
        logic signed [19:0] current_z;
        logic signed [19:0] predicted_x;
        logic signed [19:0] predicted_y;
        logic signed [19:0] predicted_z;
        logic signed [19:0] velocity_x;
        logic signed [19:0] velocity_y;
        logic signed [19:0] velocity_z;
    } item_t;

    typedef struct packed {
        logic signed [19:0] new_velocity_x;
        logic signed [19:0] new_velocity_y;
        logic signed [19:0] new_velocity_z;
        logic signed [19:0] next_position_x;
        logic signed [19:0] next_position_y;
        logic signed [19:0] next_position_z;
    } result_t;

    // Hand-off from the reflection half to the scaling half
    typedef struct packed {
        logic                 valid;
        logic [2:0][WW-1:0]   w;    // reflected velocity, signed per lane
        logic [2:0][QW-1:0]   cur;  // current position, signed per lane
    } stage_t;

    // Clamp to the signed Q10.10 range
    function automatic logic signed [19:0] sat_q20(input logic signed [27:0] x);
        logic signed [19:0] r;
        if (x > SAT_HI)
            r = SAT_HI[19:0];
        else if (x < SAT_LO)
            r = SAT_LO[19:0];
        else
            r = x[19:0];
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/pcr_cfg_regs.sv
// Configuration register file for the particle collision response unit.
// Depends on pcr_pkg for the register index codes and the cfg_t bundle.
`default_nettype none

module pcr_cfg_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [59:0]   cfg_data,
    output pcr_pkg::cfg_t      cfg
);
    import pcr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Register decode; unknown indexes leave everything as is
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_RESTITUTION:  cfg_next.restitution  = cfg_data[15:0];
                REG_TIMESTEP:     cfg_next.timestep     = cfg_data[15:0];
                REG_PLANE_NORMAL: cfg_next.plane_normal = cfg_data[47:0];
                REG_BOX_MIN:      cfg_next.box_min      = cfg_data;
                REG_BOX_MAX:      cfg_next.box_max      = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.restitution  <= RESTITUTION_RST;
            cfg_reg.timestep     <= TIMESTEP_RST;
            cfg_reg.plane_normal <= PLANE_NORMAL_RST;
            cfg_reg.box_min      <= BOX_RST;
            cfg_reg.box_max      <= BOX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/pcr_reflect.sv
// Reflection half of the pipeline: stages 1 to 4, plane reflection or box face flip.
// Depends on pcr_pkg for item_t, cfg_t, stage_t and the face/axis table.
`default_nettype none

module pcr_reflect (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire logic          item_valid,
    input  wire pcr_pkg::item_t item,
    input  wire pcr_pkg::cfg_t cfg,
    output pcr_pkg::stage_t    stage
);
    import pcr_pkg::*;

    // Unpacked views of the item and configuration
    logic signed [19:0] vel_in  [3];
    logic signed [19:0] cur_in  [3];
    logic signed [19:0] pred_in [3];
    logic signed [15:0] n_c     [3];
    logic signed [19:0] bmin_c  [3];
    logic signed [19:0] bmax_c  [3];

    // Stage 1: v*n products and face distances
    logic               s1_valid_reg;
    logic               s1_mode_reg;
    logic signed [35:0] prod_next [3];
    logic signed [35:0] prod_reg  [3];
    logic signed [20:0] dist_next [6];
    logic signed [20:0] dist_reg  [6];
    logic signed [19:0] vel1_reg  [3];
    logic signed [19:0] cur1_reg  [3];

    // Stage 2: dot product and nearest face
    logic               s2_valid_reg;
    logic               s2_mode_reg;
    logic signed [37:0] dot_next;
    logic signed [37:0] dot_reg;
    logic [1:0]         axis_next;
    logic [1:0]         axis2_reg;
    logic signed [19:0] vel2_reg  [3];
    logic signed [19:0] cur2_reg  [3];

    // Stage 3: d*n products
    logic               s3_valid_reg;
    logic               s3_mode_reg;
    logic [1:0]         axis3_reg;
    logic signed [53:0] dn_next   [3];
    logic signed [53:0] dn_reg    [3];
    logic signed [19:0] vel3_reg  [3];
    logic signed [19:0] cur3_reg  [3];

    // Stage 4: reflected velocity
    logic               s4_valid_reg;
    logic signed [55:0] refl_sum  [3];
    logic signed [55:0] refl_rnd  [3];
    logic signed [WW-1:0] w_next  [3];
    logic signed [WW-1:0] w_reg   [3];
    logic signed [19:0] cur4_reg  [3];

    always_comb
    begin
        vel_in[0]  = item.velocity_x;
        vel_in[1]  = item.velocity_y;
        vel_in[2]  = item.velocity_z;
        cur_in[0]  = item.current_x;
        cur_in[1]  = item.current_y;
        cur_in[2]  = item.current_z;
        pred_in[0] = item.predicted_x;
        pred_in[1] = item.predicted_y;
        pred_in[2] = item.predicted_z;
        for (int a = 0; a < 3; a++)
        begin
            n_c[a]    = $signed(cfg.plane_normal[16*a +: 16]);
            bmin_c[a] = $signed(cfg.box_min[20*a +: 20]);
            bmax_c[a] = $signed(cfg.box_max[20*a +: 20]);
        end
    end

    // Stage 1 logic
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            prod_next[a]     = vel_in[a] * n_c[a];
            dist_next[a]     = bmax_c[a] - pred_in[a];
            dist_next[a + 3] = pred_in[a] - bmin_c[a];
        end
    end

    // Stage 2 logic: strict less-than keeps the earliest face on ties
    always_comb
    begin
        logic signed [20:0] best;
        best      = dist_reg[0];
        axis_next = FACE_AXIS[0];
        for (int f = 1; f < 6; f++)
        begin
            if (dist_reg[f] < best)
            begin
                best      = dist_reg[f];
                axis_next = FACE_AXIS[f];
            end
        end
        dot_next = 38'(prod_reg[0]) + 38'(prod_reg[1]) + 38'(prod_reg[2]);
    end

    // Stage 3 logic
    always_comb
    begin
        for (int a = 0; a < 3; a++)
            dn_next[a] = dot_reg * n_c[a];
    end

    // Stage 4 logic: v - 2(v.n)n rounded from 38 to 10 fraction bits, or box flip
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            refl_sum[a] = (56'(vel3_reg[a]) <<< 28) - (56'(dn_reg[a]) <<< 1);
            refl_rnd[a] = (refl_sum[a] + 56'sd134217728) >>> 28;
            if (s3_mode_reg == MODE_BOX)
            begin
                if (axis3_reg == 2'(a))
                    w_next[a] = -(WW'(vel3_reg[a]));
                else
                    w_next[a] = WW'(vel3_reg[a]);
            end
            else
            begin
                w_next[a] = refl_rnd[a][WW-1:0];
            end
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= item_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_mode_reg <= item.mode;
            prod_reg    <= prod_next;
            dist_reg    <= dist_next;
            vel1_reg    <= vel_in;
            cur1_reg    <= cur_in;

            s2_mode_reg <= s1_mode_reg;
            dot_reg     <= dot_next;
            axis2_reg   <= axis_next;
            vel2_reg    <= vel1_reg;
            cur2_reg    <= cur1_reg;

            s3_mode_reg <= s2_mode_reg;
            axis3_reg   <= axis2_reg;
            dn_reg      <= dn_next;
            vel3_reg    <= vel2_reg;
            cur3_reg    <= cur2_reg;

            w_reg       <= w_next;
            cur4_reg    <= cur3_reg;
        end
    end

    // Hand-off bundle
    always_comb
    begin
        stage.valid = s4_valid_reg;
        for (int a = 0; a < 3; a++)
        begin
            stage.w[a]   = w_reg[a];
            stage.cur[a] = cur4_reg[a];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/pcr_scale.sv
// Scaling half of the pipeline: stages 5 to 8, restitution, saturation, re-prediction.
// Depends on pcr_pkg for stage_t, cfg_t, result_t and sat_q20.
`default_nettype none

module pcr_scale (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire pcr_pkg::cfg_t cfg,
    input  wire pcr_pkg::stage_t stage,
    output logic               result_valid,
    output pcr_pkg::result_t   result
);
    import pcr_pkg::*;

    logic signed [16:0] rest_s;
    logic signed [16:0] ts_s;

    // Stage 5: w * restitution
    logic               s5_valid_reg;
    logic signed [43:0] p_next   [3];
    logic signed [43:0] p_reg    [3];
    logic signed [19:0] cur5_reg [3];

    // Stage 6: round and saturate the new velocity
    logic               s6_valid_reg;
    logic signed [43:0] p_rnd    [3];
    logic signed [19:0] nv_next  [3];
    logic signed [19:0] nv6_reg  [3];
    logic signed [19:0] cur6_reg [3];

    // Stage 7: new velocity * timestep
    logic               s7_valid_reg;
    logic signed [36:0] t_next   [3];
    logic signed [36:0] t_reg    [3];
    logic signed [19:0] nv7_reg  [3];
    logic signed [19:0] cur7_reg [3];

    // Stage 8: round, add to current position, saturate
    logic               s8_valid_reg;
    logic signed [36:0] t_rnd    [3];
    logic signed [27:0] pos_sum  [3];
    logic signed [19:0] np_next  [3];
    result_t            result_next;
    result_t            result_reg;

    assign rest_s = $signed({1'b0, cfg.restitution});
    assign ts_s   = $signed({1'b0, cfg.timestep});

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            p_next[a]  = $signed(stage.w[a]) * rest_s;
            p_rnd[a]   = (p_reg[a] + 44'sd32768) >>> 16;
            nv_next[a] = sat_q20(p_rnd[a][27:0]);
            t_next[a]  = nv6_reg[a] * ts_s;
            t_rnd[a]   = (t_reg[a] + 37'sd32768) >>> 16;
            pos_sum[a] = 28'(cur7_reg[a]) + 28'($signed(t_rnd[a][20:0]));
            np_next[a] = sat_q20(pos_sum[a]);
        end
        result_next.new_velocity_x  = nv7_reg[0];
        result_next.new_velocity_y  = nv7_reg[1];
        result_next.new_velocity_z  = nv7_reg[2];
        result_next.next_position_x = np_next[0];
        result_next.next_position_y = np_next[1];
        result_next.next_position_z = np_next[2];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s5_valid_reg <= stage.valid;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int a = 0; a < 3; a++)
            begin
                p_reg[a]    <= p_next[a];
                cur5_reg[a] <= $signed(stage.cur[a]);
            end
            nv6_reg    <= nv_next;
            cur6_reg   <= cur5_reg;
            t_reg      <= t_next;
            nv7_reg    <= nv6_reg;
            cur7_reg   <= cur6_reg;
            result_reg <= result_next;
        end
    end

    assign result_valid = s8_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

>>> rtl/core/particle_collision_response_unit.sv
// Particle collision response unit: plane reflection or nearest-box-face flip,
// then restitution damping and re-prediction, one particle per transfer.
// Pipeline: 8 register stages between the input transfer and the result.
// Throughput: one item per cycle; the whole pipeline holds only while a result is stalled.
// Reset: asynchronous, active low; clears all valid bits and loads register defaults.
`default_nettype none

module particle_collision_response_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire pcr_pkg::item_t item,
    output logic               result_valid,
    input  wire logic          result_stall,
    output pcr_pkg::result_t   result,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [59:0]   cfg_data
);
    import pcr_pkg::*;

    cfg_t   cfg;
    stage_t stage;
    logic   advance;

    // Pipeline moves unless the output register holds an untaken result
    assign advance    = !(result_valid && result_stall);
    assign item_stall = !advance;

    pcr_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pcr_reflect u_reflect (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item),
        .cfg        (cfg),
        .stage      (stage)
    );

    pcr_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .cfg          (cfg),
        .stage        (stage),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

>>> rtl/core/pcr_checker.sv
// Port-level checker for the particle collision response unit, with its bind.
// Depends on pcr_pkg and the assertion macro header.
`default_nettype none

`include "particle_collision_response_unit_assert.svh"

module pcr_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    input  wire logic          item_stall,
    input  wire logic          result_valid,
    input  wire logic          result_stall,
    input  wire pcr_pkg::result_t result,
    input  wire logic          cfg_ready
);
    // Result offered but held off by the receiver
    logic out_held;

    assign out_held = result_valid && result_stall;

    // A stalled result keeps its payload
    `PCR_ASSERT_NXT(a_result_hold, out_held, result_valid && $stable(result), "result moved")

    // Back-pressure only comes from the result side
    `PCR_ASSERT_IMP(a_stall_source, item_stall, out_held, "input stalled without output stall")

    // A free output side never blocks an offered item
    `PCR_ASSERT_IMP(a_no_idle_stall, item_valid && !result_stall, !item_stall, "idle stall")

    // Register writes are never refused
    `PCR_ASSERT_HOLD(a_cfg_ready, cfg_ready, "configuration write refused")

endmodule

bind particle_collision_response_unit pcr_checker u_pcr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_ready    (cfg_ready)
);

`default_nettype wire

>>> dv/tb.sv
// Self-checking bench for particle_collision_response_unit.
// Uses pcr_pkg for the port types and register indexes; needs only the RTL.
`timescale 1ns / 100ps

module tb;
    import pcr_pkg::*;

    localparam int          PIPE_LATENCY = 8;
    localparam int          DRAIN_LIMIT  = 20000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          PHASES       = 8;
    localparam int          PHASE_ITEMS  = 110;
    localparam logic [2:0]  REG_UNUSED   = 3'd7;
    localparam longint      Q20_MAX      = 524287;
    localparam longint      Q20_MIN      = -524288;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  cfg_idx;
        logic [59:0] cfg_val;
        item_t       it;
        bit          typed;
        result_t     typed_res;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    item_t       item;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [59:0] cfg_data;

    // Shadow copy of the configuration registers
    logic [15:0] restitution_q;
    logic [15:0] timestep_q;
    logic [47:0] normal_q;
    logic [59:0] box_min_q;
    logic [59:0] box_max_q;

    result_t       response_q[$];
    result_t       expected_head;
    directed_row_t directed_q[$];
    int            mismatch_count = 0;
    int            send_idle_pct  = 0;
    int            stall_pct      = 0;
    int            hold_cycles    = 0;

    particle_collision_response_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic longint clamp_q20(longint x);
        if (x > Q20_MAX)
            return Q20_MAX;
        if (x < Q20_MIN)
            return Q20_MIN;
        return x;
    endfunction

    // Reflection, damping and re-prediction of one particle
    function automatic result_t predict_response(item_t it);
        longint  cur[3], prd[3], vel[3], w[3], nrm[3], bmin[3], bmax[3];
        longint  nv[3], np[3];
        longint  dot, r, face_dist, best, rest, step;
        int      axis;
        result_t res;
        cur[0] = $signed(it.current_x);
        cur[1] = $signed(it.current_y);
        cur[2] = $signed(it.current_z);
        prd[0] = $signed(it.predicted_x);
        prd[1] = $signed(it.predicted_y);
        prd[2] = $signed(it.predicted_z);
        vel[0] = $signed(it.velocity_x);
        vel[1] = $signed(it.velocity_y);
        vel[2] = $signed(it.velocity_z);
        rest = longint'(restitution_q);
        step = longint'(timestep_q);
        for (int a = 0; a < 3; a++)
        begin
            w[a]    = vel[a];
            nrm[a]  = $signed(normal_q[16*a +: 16]);
            bmin[a] = $signed(box_min_q[20*a +: 20]);
            bmax[a] = $signed(box_max_q[20*a +: 20]);
        end
        if (it.mode == MODE_BOX)
        begin
            // nearest face, ties go to the earlier of +x +y +z -x -y -z
            best = bmax[0] - prd[0];
            axis = 0;
            for (int f = 1; f < 6; f++)
            begin
                if (f < 3)
                    face_dist = bmax[f % 3] - prd[f % 3];
                else
                    face_dist = prd[f % 3] - bmin[f % 3];
                if (face_dist < best)
                begin
                    best = face_dist;
                    axis = f % 3;
                end
            end
            w[axis] = -vel[axis];
        end
        else
        begin
            // v - 2(v.n)n, 38 fraction bits, rounded half up to 10
            dot = 0;
            for (int a = 0; a < 3; a++)
                dot += vel[a] * nrm[a];
            for (int a = 0; a < 3; a++)
            begin
                r    = (vel[a] <<< 28) - 2 * dot * nrm[a];
                w[a] = (r + (longint'(1) <<< 27)) >>> 28;
            end
        end
        for (int a = 0; a < 3; a++)
        begin
            nv[a] = clamp_q20((w[a] * rest + 32768) >>> 16);
            np[a] = clamp_q20(cur[a] + ((nv[a] * step + 32768) >>> 16));
        end
        res.new_velocity_x  = nv[0][19:0];
        res.new_velocity_y  = nv[1][19:0];
        res.new_velocity_z  = nv[2][19:0];
        res.next_position_x = np[0][19:0];
        res.next_position_y = np[1][19:0];
        res.next_position_z = np[2][19:0];
        return res;
    endfunction

    function automatic logic [59:0] pack_q20(int x, int y, int z);
        return {z[19:0], y[19:0], x[19:0]};
    endfunction

    function automatic logic [47:0] pack_q14(int x, int y, int z);
        return {z[15:0], y[15:0], x[15:0]};
    endfunction

    function automatic directed_row_t cfg_row(logic [2:0] idx, logic [59:0] val);
        directed_row_t row;
        row           = '{kind: ROW_CFG, default: '0};
        row.kind      = ROW_CFG;
        row.cfg_idx   = idx;
        row.cfg_val   = val;
        return row;
    endfunction

    // at_rest: velocity comes out zero and position equals current
    function automatic directed_row_t item_row(logic mode, logic [59:0] cur,
                                               logic [59:0] prd, logic [59:0] vel,
                                               bit at_rest);
        directed_row_t row;
        row                 = '{kind: ROW_ITEM, default: '0};
        row.kind            = ROW_ITEM;
        row.it.mode         = mode;
        row.it.current_x    = cur[19:0];
        row.it.current_y    = cur[39:20];
        row.it.current_z    = cur[59:40];
        row.it.predicted_x  = prd[19:0];
        row.it.predicted_y  = prd[39:20];
        row.it.predicted_z  = prd[59:40];
        row.it.velocity_x   = vel[19:0];
        row.it.velocity_y   = vel[39:20];
        row.it.velocity_z   = vel[59:40];
        row.typed           = at_rest;
        row.typed_res.next_position_x = cur[19:0];
        row.typed_res.next_position_y = cur[39:20];
        row.typed_res.next_position_z = cur[59:40];
        return row;
    endfunction

    task automatic build_directed();
        logic [59:0] mid;
        logic [59:0] fast;
        mid  = pack_q20(500, 600, 700);
        fast = pack_q20(524287, -524288, 524287);
        // reset configuration: unit normal +x, degenerate box at origin
        directed_q.push_back(item_row(MODE_PLANE, pack_q20(524287, -524288, 0), 0, 0, 1));
        directed_q.push_back(item_row(MODE_BOX, pack_q20(-524288, 524287, 1),
                                      pack_q20(524287, -524288, 0), 0, 1));
        directed_q.push_back(item_row(MODE_PLANE, 0, 0, pack_q20(1024, 0, 0), 0));
        directed_q.push_back(item_row(MODE_PLANE, pack_q20(524287, 524287, -524288),
                                      0, fast, 0));
        directed_q.push_back(item_row(MODE_BOX, 0, 0, pack_q20(524287, -524288, -1), 0));
        // unit box, the +x, -y, +z and -x faces in turn, outside point and a face tie
        directed_q.push_back(cfg_row(REG_BOX_MIN, pack_q20(-1024, -1024, -1024)));
        directed_q.push_back(cfg_row(REG_BOX_MAX, pack_q20(1024, 1024, 1024)));
        directed_q.push_back(item_row(MODE_BOX, 0, pack_q20(1000, 0, 0), mid, 0));
        directed_q.push_back(item_row(MODE_BOX, 0, pack_q20(0, -1000, 0), mid, 0));
        directed_q.push_back(item_row(MODE_BOX, 0, pack_q20(0, 0, 1000), mid, 0));
        directed_q.push_back(item_row(MODE_BOX, 0, pack_q20(-1000, 0, 0), mid, 0));
        directed_q.push_back(item_row(MODE_BOX, 0, pack_q20(2000, 0, 0), mid, 0));
        directed_q.push_back(item_row(MODE_BOX, 0, pack_q20(1024, 1024, 0), mid, 0));
        // inverted box
        directed_q.push_back(cfg_row(REG_BOX_MIN, pack_q20(1024, 1024, 1024)));
        directed_q.push_back(cfg_row(REG_BOX_MAX, pack_q20(-1024, -1024, -1024)));
        directed_q.push_back(item_row(MODE_BOX, 0, 0, pack_q20(-300, 400, -500), 0));
        // non-unit normal, junk above the register width
        directed_q.push_back(cfg_row(REG_PLANE_NORMAL,
                                     {12'hABC, pack_q14(32767, -32768, 12345)}));
        directed_q.push_back(item_row(MODE_PLANE, 0, 0,
                                      pack_q20(524287, 524287, -524288), 0));
        directed_q.push_back(cfg_row(REG_PLANE_NORMAL, pack_q14(0, 0, -16384)));
        directed_q.push_back(item_row(MODE_PLANE, pack_q20(5000, -5000, 0), 0,
                                      pack_q20(100, -200, 300), 0));
        // restitution zero, with high junk bits; then full scale
        directed_q.push_back(cfg_row(REG_RESTITUTION, {44'hFFF_FFFF_FFFF, 16'd0}));
        directed_q.push_back(item_row(MODE_PLANE, pack_q20(-77, 88, -99), 0, fast, 1));
        directed_q.push_back(cfg_row(REG_RESTITUTION, 60'hFFFF));
        directed_q.push_back(item_row(MODE_PLANE, 0, 0, fast, 0));
        // zero and full timestep
        directed_q.push_back(cfg_row(REG_TIMESTEP, 60'd0));
        directed_q.push_back(item_row(MODE_PLANE, pack_q20(123, -456, 789), 0,
                                      pack_q20(700, -700, 7000), 0));
        directed_q.push_back(cfg_row(REG_TIMESTEP, 60'hFFFF));
        directed_q.push_back(item_row(MODE_PLANE, fast, 0, fast, 0));
        // write to an index past the last register does nothing
        directed_q.push_back(cfg_row(REG_UNUSED, '1));
        directed_q.push_back(item_row(MODE_BOX, fast, pack_q20(3, -3, 3), fast, 0));
    endtask

    task automatic reset_shadow();
        restitution_q = 16'd64880;
        timestep_q    = 16'd1092;
        normal_q      = 48'd16384;
        box_min_q     = '0;
        box_max_q     = '0;
    endtask

    task automatic write_register(logic [2:0] idx, logic [59:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_RESTITUTION:  restitution_q = val[15:0];
            REG_TIMESTEP:     timestep_q    = val[15:0];
            REG_PLANE_NORMAL: normal_q      = val[47:0];
            REG_BOX_MIN:      box_min_q     = val;
            REG_BOX_MAX:      box_max_q     = val;
            default:          ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One input transfer, with random idle cycles ahead of it
    task automatic send_item(item_t it, bit typed, result_t typed_res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (item_stall);
        response_q.push_back(typed ? typed_res : predict_response(it));
    endtask

    // Stop sending, wait for every outstanding result, then let the pipe settle
    task automatic drain_results();
        int waited;
        waited = 0;
        @(negedge clk);
        item_valid <= 1'b0;
        while (response_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (response_q.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", response_q.size()));
            response_q.delete();
        end
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [19:0] rand_q20();
        int pick;
        int near;
        pick = $urandom_range(9);
        near = $urandom_range(8191);
        case (pick)
            0:       return 20'h7FFFF;
            1:       return 20'h80000;
            2, 3, 4: return 20'(near - 4096);
            default: return 20'($urandom);
        endcase
    endfunction

    function automatic item_t rand_item();
        item_t it;
        it.mode        = 1'($urandom_range(1));
        it.current_x   = rand_q20();
        it.current_y   = rand_q20();
        it.current_z   = rand_q20();
        it.predicted_x = rand_q20();
        it.predicted_y = rand_q20();
        it.predicted_z = rand_q20();
        it.velocity_x  = rand_q20();
        it.velocity_y  = rand_q20();
        it.velocity_z  = rand_q20();
        return it;
    endfunction

    task automatic program_random_config();
        logic [63:0] raw;
        logic [59:0] val;
        logic [59:0] lo_vec;
        logic [59:0] hi_vec;
        logic [19:0] lo;
        logic [19:0] hi;
        logic [19:0] tmp;
        int          pick;
        int          ax;
        // restitution: zero, full scale or anything
        raw  = {$urandom, $urandom};
        val  = raw[59:0];
        pick = $urandom_range(9);
        val[15:0] = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom);
        write_register(REG_RESTITUTION, val);
        // timestep: one, full scale or anything nonzero
        raw  = {$urandom, $urandom};
        val  = raw[59:0];
        pick = $urandom_range(9);
        val[15:0] = (pick == 0) ? 16'd1 : (pick == 1) ? 16'hFFFF :
                    16'($urandom_range(65535, 1));
        write_register(REG_TIMESTEP, val);
        // normal: signed axis unit vector, raw bits, or components near unit size
        raw  = {$urandom, $urandom};
        val  = raw[59:0];
        pick = $urandom_range(3);
        if (pick == 0)
        begin
            ax = $urandom_range(2);
            val[47:0] = '0;
            val[16*ax +: 16] = $urandom_range(1) ? 16'd16384 : -16'sd16384;
        end
        else if (pick > 1)
        begin
            for (int a = 0; a < 3; a++)
                val[16*a +: 16] = 16'(int'($urandom_range(32768)) - 16384);
        end
        write_register(REG_PLANE_NORMAL, val);
        // box: mostly well ordered, sometimes inverted
        for (int a = 0; a < 3; a++)
        begin
            lo = rand_q20();
            hi = rand_q20();
            if ($signed(lo) > $signed(hi) && $urandom_range(9) < 8)
            begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end
            lo_vec[20*a +: 20] = lo;
            hi_vec[20*a +: 20] = hi;
        end
        write_register(REG_BOX_MIN, lo_vec);
        write_register(REG_BOX_MAX, hi_vec);
    endtask

    task automatic set_idling(idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 86; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 86; end
            IDLE_BOTH:     begin send_idle_pct = 22; stall_pct = 22; end
            default:       ;
        endcase
    endtask

    task automatic check_field(string name, logic [19:0] got, logic [19:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d",
                                      name, $signed(got), $signed(want)));
    endtask

    // Receiver stall: a counted hold-off when requested, random otherwise
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                result_stall <= 1'b1;
                hold_cycles--;
            end
            else
                result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Compare each result transfer with the oldest outstanding prediction
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (response_q.size() == 0)
                report_mismatch("result transfer with nothing outstanding");
            else
            begin
                expected_head = response_q.pop_front();
                check_field("new_velocity_x", result.new_velocity_x,
                            expected_head.new_velocity_x);
                check_field("new_velocity_y", result.new_velocity_y,
                            expected_head.new_velocity_y);
                check_field("new_velocity_z", result.new_velocity_z,
                            expected_head.new_velocity_z);
                check_field("next_position_x", result.next_position_x,
                            expected_head.next_position_x);
                check_field("next_position_y", result.next_position_y,
                            expected_head.next_position_y);
                check_field("next_position_z", result.next_position_z,
                            expected_head.next_position_z);
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        reset_shadow();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table, no idling
        build_directed();
        foreach (directed_q[i])
        begin
            if (directed_q[i].kind == ROW_CFG)
            begin
                drain_results();
                write_register(directed_q[i].cfg_idx, directed_q[i].cfg_val);
            end
            else
                send_item(directed_q[i].it, directed_q[i].typed, directed_q[i].typed_res);
        end

        // random phases, each with its own configuration and idling profile
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            program_random_config();
            set_idling(idle_mode_t'(phase % 4));
            // long receiver hold-off while items keep coming: fills the pipe
            if (phase == 0)
                hold_cycles = HOLD_CYCLES;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 5 && n == PHASE_ITEMS / 2)
                    drain_results();
                send_item(rand_item(), 1'b0, '0);
            end
        end
        drain_results();

        if (mismatch_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/pcr_pkg.sv
rtl/core/pcr_cfg_regs.sv
rtl/core/pcr_reflect.sv
rtl/core/pcr_scale.sv
rtl/core/particle_collision_response_unit.sv
rtl/core/pcr_checker.sv
dv/tb.sv
